// File: hw/rtl/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg
// shared types and codes of the page framebuffer raster engine
// ----------------------------------------------------------------------------
package pfb_pkg;

	localparam int unsigned SCREEN_WIDTH_DEF  = 128;
	localparam int unsigned SCREEN_HEIGHT_DEF = 64;

	// command codes on the func field
	localparam logic [2:0] FUNC_CLEAR   = 3'd0;
	localparam logic [2:0] FUNC_FILL    = 3'd1;
	localparam logic [2:0] FUNC_INVERT  = 3'd2;
	localparam logic [2:0] FUNC_OUTLINE = 3'd3;
	localparam logic [2:0] FUNC_READ    = 3'd4;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_CLEAR,
		OP_FILL,
		OP_INVERT,
		OP_OUTLINE,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] w;
		logic [7:0] h;
		logic       color;
		logic       rd_ok;
		logic [2:0] rd_page;
		logic [6:0] rd_col;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_RMW,
		ST_READ,
		ST_DONE
	} eng_state_t;

endpackage

// File: hw/rtl/pfb_cmd_if.sv
// ----------------------------------------------------------------------------
// pfb_cmd_if
// command channel: valid/ready with the drawing command payload
// ----------------------------------------------------------------------------
interface pfb_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [7:0] x;
	logic [7:0] y;
	logic [7:0] width;
	logic [7:0] height;
	logic       color;
	logic [2:0] read_page;
	logic [6:0] read_column;

	modport source (output valid, func, x, y, width, height, color, read_page,
		read_column, input ready);
	modport sink (input valid, func, x, y, width, height, color, read_page,
		read_column, output ready);
endinterface

// File: hw/rtl/pfb_rsp_if.sv
// ----------------------------------------------------------------------------
// pfb_rsp_if
// result channel: valid/ready with the read byte
// ----------------------------------------------------------------------------
interface pfb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

// File: hw/rtl/page_framebuffer_raster_engine.sv
// ----------------------------------------------------------------------------
// page_framebuffer_raster_engine
// monochrome page-addressed framebuffer with clear, fill, invert, outline and
// byte read-back commands
// ----------------------------------------------------------------------------
// channel | dir | payload                                              | per transaction
// cmd     | in  | func x y width height color read_page read_column    | one command
// rsp     | out | read_data                                            | one result
//
// a clear writes one byte a cycle; a read registers the ram byte before the result
// a rectangle scans every page of each on-screen column, moves straight past each
// off-screen column and adds a read-modify-write step per on-screen byte whose
// mask is not empty, set by the single ram port doing read-modify-write
// after reset a clearing pass over all DEPTH bytes (1024 by default) runs, cmd not ready
// a two-entry command queue decouples cmd from the engine; a stalled rsp holds
// the result register and the engine waits only when a second result is done
// ----------------------------------------------------------------------------
module page_framebuffer_raster_engine #(
	parameter int unsigned SCREEN_WIDTH  = pfb_pkg::SCREEN_WIDTH_DEF,
	parameter int unsigned SCREEN_HEIGHT = pfb_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pfb_cmd_if.sink   cmd,
	pfb_rsp_if.source rsp
);
	import pfb_pkg::*;

	// queue head handed from front to back
	logic head_valid;
	cmd_t head;
	logic pop;
	// the front holds off commands until the power-up clear finishes
	logic init_done;

	pfb_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.init_done  (init_done),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// engine walks bytes column by column, every page of each column
	pfb_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.init_done  (init_done),
		.rsp        (rsp)
	);
endmodule

// File: hw/rtl/pfb_ram.sv
// ----------------------------------------------------------------------------
// pfb_ram
// generic single-clock ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pfb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hw/rtl/pfb_front.sv
// ----------------------------------------------------------------------------
// pfb_front
// takes commands, decodes them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module pfb_front #(
	parameter int unsigned SCREEN_WIDTH  = pfb_pkg::SCREEN_WIDTH_DEF,
	parameter int unsigned SCREEN_HEIGHT = pfb_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	pfb_cmd_if.sink       cmd,
	input  logic          init_done,
	input  logic          pop,
	output logic          head_valid,
	output pfb_pkg::cmd_t head
);
	import pfb_pkg::*;

	localparam int unsigned PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;

	cmd_t       dec;
	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       empty_rect;

	always_comb begin
		empty_rect  = (cmd.width == 8'd0) || (cmd.height == 8'd0);
		dec.x       = cmd.x;
		dec.y       = cmd.y;
		dec.w       = cmd.width;
		dec.h       = cmd.height;
		dec.color   = cmd.color;
		dec.rd_page = cmd.read_page;
		dec.rd_col  = cmd.read_column;
		dec.rd_ok   = (32'(cmd.read_page) < PAGE_COUNT) &&
			(32'(cmd.read_column) < SCREEN_WIDTH);
		unique case (cmd.func)
			FUNC_CLEAR:   dec.op = OP_CLEAR;
			FUNC_FILL:    dec.op = empty_rect ? OP_NOP : OP_FILL;
			FUNC_INVERT:  dec.op = empty_rect ? OP_NOP : OP_INVERT;
			FUNC_OUTLINE: dec.op = empty_rect ? OP_NOP : OP_OUTLINE;
			FUNC_READ:    dec.op = OP_READ;
			default:      dec.op = OP_NOP;
		endcase
	end

	assign cmd.ready  = init_done && (cnt_q != 2'd2);
	assign push       = cmd.valid && cmd.ready;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end
endmodule

// File: hw/rtl/pfb_back.sv
// ----------------------------------------------------------------------------
// pfb_back
// raster engine: clears, walks rectangle bytes read-modify-write, reads back
// ----------------------------------------------------------------------------
module pfb_back #(
	parameter int unsigned SCREEN_WIDTH  = pfb_pkg::SCREEN_WIDTH_DEF,
	parameter int unsigned SCREEN_HEIGHT = pfb_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  pfb_pkg::cmd_t head,
	output logic          pop,
	output logic          init_done,
	pfb_rsp_if.source     rsp
);
	import pfb_pkg::*;

	localparam int unsigned PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
	localparam int unsigned DEPTH      = SCREEN_WIDTH * PAGE_COUNT;
	localparam int unsigned AW         = $clog2(DEPTH);
	localparam int unsigned PW         = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

	eng_state_t    state_q, state_d;
	cmd_t          cmd_q, cmd_d;
	logic [7:0]    j_q, j_d;
	logic [PW-1:0] page_q, page_d;
	logic [AW-1:0] base_q, base_d;
	logic [AW-1:0] addr_q, addr_d;
	logic [7:0]    mask_q, mask_d;
	logic [7:0]    data_q, data_d;
	logic          init_q, init_d;
	logic          res_valid_q;
	logic [7:0]    res_q;
	logic          res_load;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	logic [7:0]    col;
	logic          col_ok;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] rd_addr;
	logic          full_col;
	logic          last_col;
	logic          last_page;
	logic [7:0]    mask;
	logic [7:0]    row;
	logic [7:0]    rel;
	logic          in_rows;
	logic          edge_row;
	logic [7:0]    modified;

	pfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// byte mask of the current column and page
	always_comb begin
		col       = cmd_q.x + j_q;
		col_ok    = 32'(col) < SCREEN_WIDTH;
		cur_addr  = base_q + AW'(col);
		full_col  = (j_q == 8'd0) || (j_q == cmd_q.w - 8'd1);
		last_col  = (j_q == cmd_q.w - 8'd1);
		last_page = (page_q == PW'(PAGE_COUNT - 1));
		rd_addr   = head.rd_ok ?
			AW'(32'(head.rd_page) * SCREEN_WIDTH + 32'(head.rd_col)) : '0;
		row       = 8'd0;
		rel       = 8'd0;
		in_rows   = 1'b0;
		edge_row  = 1'b0;
		mask      = 8'd0;
		for (int b = 0; b < 8; b++) begin
			row      = 8'({page_q, 3'(b)});
			rel      = row - cmd_q.y;
			in_rows  = rel < cmd_q.h;
			edge_row = (rel == 8'd0) || (rel == cmd_q.h - 8'd1);
			mask[b]  = (32'(row) < SCREEN_HEIGHT) &&
				((cmd_q.op == OP_OUTLINE) ? (full_col ? in_rows : edge_row) : in_rows);
		end
	end

	always_comb begin
		unique case (cmd_q.op)
			OP_FILL:    modified = cmd_q.color ? (ram_rdata | mask_q) : (ram_rdata & ~mask_q);
			OP_INVERT:  modified = ram_rdata ^ mask_q;
			OP_OUTLINE: modified = ram_rdata | mask_q;
			default:    modified = ram_rdata;
		endcase
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		j_d       = j_q;
		page_d    = page_q;
		base_d    = base_q;
		addr_d    = addr_q;
		mask_d    = mask_q;
		data_d    = data_q;
		init_d    = init_q;
		pop       = 1'b0;
		res_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = 8'd0;
		ram_raddr = cur_addr;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				addr_d = addr_q + AW'(1);
				if (addr_q == AW'(DEPTH - 1)) begin
					addr_d  = '0;
					init_d  = 1'b1;
					state_d = init_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				ram_raddr = rd_addr;
				if (head_valid) begin
					pop    = 1'b1;
					cmd_d  = head;
					data_d = 8'd0;
					j_d    = 8'd0;
					page_d = '0;
					base_d = '0;
					addr_d = '0;
					unique case (head.op)
						OP_CLEAR:                        state_d = ST_CLEAR;
						OP_FILL, OP_INVERT, OP_OUTLINE:  state_d = ST_SCAN;
						OP_READ:                         state_d = ST_READ;
						default:                         state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN, ST_RMW: begin
				if (state_q == ST_RMW) begin
					ram_we    = 1'b1;
					ram_wdata = modified;
				end
				if ((state_q == ST_SCAN) && col_ok && (mask != 8'd0)) begin
					addr_d  = cur_addr;
					mask_d  = mask;
					state_d = ST_RMW;
				end else if (last_page || !col_ok) begin
					page_d = '0;
					base_d = '0;
					j_d    = j_q + 8'd1;
					state_d = last_col ? ST_DONE : ST_SCAN;
				end else begin
					page_d  = page_q + PW'(1);
					base_d  = base_q + AW'(SCREEN_WIDTH);
					state_d = ST_SCAN;
				end
			end
			ST_READ: begin
				data_d  = cmd_q.rd_ok ? ram_rdata : 8'd0;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!res_valid_q || rsp.ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			init_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			init_q  <= init_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		j_q    <= j_d;
		page_q <= page_d;
		base_q <= base_d;
		mask_q <= mask_d;
		data_q <= data_d;
		if (res_load) begin
			res_q <= data_q;
		end
	end

	assign init_done     = init_q;
	assign rsp.valid     = res_valid_q;
	assign rsp.read_data = res_q;
endmodule
